/* rtl/core/ible_pkg.sv */
// shared types and constants for the indexed byte list engine
// request codes, status codes, controller states and the control/status bundles
// no dependencies
package ible_pkg;

    // request codes carried on the input tuser
    typedef enum logic [2:0] {
        REQ_INSERT  = 3'd0,
        REQ_DELETE  = 3'd1,
        REQ_READ    = 3'd2,
        REQ_REVERSE = 3'd3,
        REQ_CLEAR   = 3'd4
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REV_SHIFT,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming request word
        logic exec;    // insert, delete, read or clear on the cell row
        logic mirror;  // flip the whole cell row end for end
        logic shift;   // move every cell one place toward the head
        logic finish;  // build the result word into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_req req;         // request held for this word
        logic multi;       // list holds two or more entries
        logic steps_zero;  // alignment shifts after a mirror are done
        logic out_free;    // output register can take a result this cycle
    } t_stat;

    // widths of the fixed payload fields
    localparam int unsigned PosW = 8;
    localparam int unsigned ValW = 8;

endpackage

/* rtl/core/ible_datapath.sv */
// datapath of the indexed byte list engine: row of byte cells, count, output register
// cells move in parallel: those from the position up on insert and delete, every cell on mirror and shift
// depends on ible_pkg
module ible_datapath #(
    parameter int DEPTH = 16,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ible_pkg::t_cmd               i_cmd,
    output ible_pkg::t_stat              o_stat,
    input  logic [2:0]                   i_req_type,
    input  logic [ible_pkg::PosW-1:0]    i_position,
    input  logic [ible_pkg::ValW-1:0]    i_item_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_read_data,
    output logic [1:0]                   o_status,
    output logic [CW-1:0]                o_count,
    output logic [7:0]                   o_first_value,
    output logic [7:0]                   o_last_value,
    output logic                         o_is_empty
);

    // captured request
    ible_pkg::t_req            r_req;
    logic [ible_pkg::PosW-1:0] r_pos;
    logic [ible_pkg::ValW-1:0] r_val;

    // list storage and bookkeeping
    logic [7:0]        r_cells [DEPTH];
    logic [7:0]        n_cells [DEPTH];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_steps;
    logic [7:0]        r_rd;
    ible_pkg::t_status r_status;

    // output register
    logic              r_o_valid;
    logic [7:0]        r_o_rd;
    logic [1:0]        r_o_status;
    logic [CW-1:0]     r_o_count;
    logic [7:0]        r_o_first;
    logic [7:0]        r_o_last;
    logic              r_o_empty;

    logic [7:0]    pos_mag;
    logic [7:0]    count_ext;
    logic          ins_ok;
    logic          acc_ok;
    logic          full;
    logic          do_ins;
    logic          do_del;
    logic [CW-1:0] tail_idx;
    logic [IW-1:0] rd_addr;
    logic [7:0]    rd_word;

    // position checks against the current length
    assign pos_mag   = {1'b0, r_pos[6:0]};
    assign count_ext = {{(8 - CW){1'b0}}, r_count};
    assign ins_ok    = !r_pos[7] && (pos_mag <= count_ext);
    assign acc_ok    = !r_pos[7] && (pos_mag < count_ext);
    assign full      = (r_count == CW'(DEPTH));
    assign do_ins    = i_cmd.exec && (r_req == ible_pkg::REQ_INSERT) && ins_ok && !full;
    assign do_del    = i_cmd.exec && (r_req == ible_pkg::REQ_DELETE) && acc_ok;

    // single read port: request position during exec, tail during finish
    assign tail_idx = r_count - CW'(1);
    assign rd_addr  = i_cmd.finish ? tail_idx[IW-1:0] : r_pos[IW-1:0];
    assign rd_word  = r_cells[rd_addr];

    // next value of every cell
    always_comb begin
        n_cells = r_cells;
        for (int k = 0; k < DEPTH; k++) begin
            if (do_ins) begin
                if (8'(k) > pos_mag) begin
                    n_cells[k] = r_cells[(k == 0) ? 0 : k - 1];
                end else if (8'(k) == pos_mag) begin
                    n_cells[k] = r_val;
                end
            end else if (do_del) begin
                if (8'(k) >= pos_mag) begin
                    n_cells[k] = r_cells[(k < DEPTH - 1) ? k + 1 : k];
                end
            end else if (i_cmd.mirror) begin
                n_cells[k] = r_cells[DEPTH - 1 - k];
            end else if (i_cmd.shift) begin
                n_cells[k] = r_cells[(k < DEPTH - 1) ? k + 1 : k];
            end
        end
    end

    // next length
    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.exec && (r_req == ible_pkg::REQ_CLEAR)) begin
            n_count = '0;
        end
    end

    // cell row, no reset
    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    // request capture and per-request result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= ible_pkg::t_req'(i_req_type);
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (i_cmd.exec) begin
            r_rd     <= 8'd0;
            r_status <= ible_pkg::ST_OK;
            case (r_req)
                ible_pkg::REQ_INSERT: begin
                    if (!ins_ok) begin
                        r_status <= ible_pkg::ST_RANGE;
                    end else if (full) begin
                        r_status <= ible_pkg::ST_FULL;
                    end
                end
                ible_pkg::REQ_DELETE: begin
                    if (!acc_ok) begin
                        r_status <= ible_pkg::ST_RANGE;
                    end
                end
                ible_pkg::REQ_READ: begin
                    if (!acc_ok) begin
                        r_status <= ible_pkg::ST_RANGE;
                    end else begin
                        r_rd <= rd_word;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.mirror) begin
            r_rd     <= 8'd0;
            r_status <= ible_pkg::ST_OK;
        end
    end

    // length and alignment step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_steps <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.mirror) begin
                r_steps <= CW'(DEPTH) - r_count;
            end else if (i_cmd.shift) begin
                r_steps <= r_steps - CW'(1);
            end
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_rd     <= r_rd;
            r_o_status <= r_status;
            r_o_count  <= r_count;
            r_o_first  <= (r_count != '0) ? r_cells[0] : 8'd0;
            r_o_last   <= (r_count != '0) ? rd_word : 8'd0;
            r_o_empty  <= (r_count == '0);
        end
    end

    // status toward the controller
    assign o_stat.req        = r_req;
    assign o_stat.multi      = (r_count > CW'(1));
    assign o_stat.steps_zero = (r_steps == '0);
    assign o_stat.out_free   = !r_o_valid || i_ready;

    assign o_valid       = r_o_valid;
    assign o_read_data   = r_o_rd;
    assign o_status      = r_o_status;
    assign o_count       = r_o_count;
    assign o_first_value = r_o_first;
    assign o_last_value  = r_o_last;
    assign o_is_empty    = r_o_empty;

endmodule

/* rtl/core/ible_ctrl.sv */
// controller of the indexed byte list engine
// sequences accept, execute, reverse alignment and result hand-off
// depends on ible_pkg
module ible_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ible_pkg::t_stat i_stat,
    output ible_pkg::t_cmd  o_cmd
);

    ible_pkg::t_state r_state;
    ible_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ible_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ible_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ible_pkg::S_EXEC;
                end
            end
            ible_pkg::S_EXEC: begin
                if ((i_stat.req == ible_pkg::REQ_REVERSE) && i_stat.multi) begin
                    o_cmd.mirror = 1'b1;
                    n_state      = ible_pkg::S_REV_SHIFT;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = ible_pkg::S_FINISH;
                end
            end
            ible_pkg::S_REV_SHIFT: begin
                // slide the mirrored entries back down to the head
                if (i_stat.steps_zero) begin
                    n_state = ible_pkg::S_FINISH;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ible_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ible_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ible_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/indexed_byte_list_engine.sv */
// top level of the indexed byte list engine: stream ports, controller and datapath
// depends on ible_pkg, ible_ctrl, ible_datapath
//
// usage
//   input stream: one request word per handshake; tuser carries the request code
//   (insert, delete, read, reverse, clear), tdata the position and the byte to insert
//   output stream: one result word per request with read byte, status, length,
//   head byte, tail byte and empty flag
//   sequence: the result is registered after the execute and finish steps for insert,
//   delete, read, clear and unused codes; a reverse of two or more entries also runs
//   the one-place-per-cycle shift of the cell row that follows the mirror, until the
//   entries are back at the head
//   a request passes the idle, execute and finish steps, a reverse also the shift step
//   s_axis_tready is high only while the controller is idle; a new request is
//   taken while the previous result still waits in the output register
//   a stalled receiver holds the result; the next request then waits in the
//   finish step until the output register is taken
//   reset (synchronous, active low) empties the list and drops any pending result;
//   cell contents are not cleared
module indexed_byte_list_engine #(
    parameter int DEPTH = 16,
    localparam int CW  = $clog2(DEPTH + 1),
    localparam int OTW = ((27 + CW + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [15:0]    i_s_axis_tdata,   // position[7:0], item_value[15:8]
    input  logic [2:0]     i_s_axis_tuser,   // req_type[2:0]
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [OTW-1:0] o_m_axis_tdata    // read_data, status, count, first_value,
                                             // last_value, is_empty, zero fill
);

    ible_pkg::t_cmd  cmd;
    ible_pkg::t_stat stat;

    logic [7:0]    read_data;
    logic [1:0]    status;
    logic [CW-1:0] count;
    logic [7:0]    first_value;
    logic [7:0]    last_value;
    logic          is_empty;

    // request sequencer
    ible_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // cell row and result register
    ible_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_s_axis_tuser),
        .i_position    (i_s_axis_tdata[7:0]),
        .i_item_value  (i_s_axis_tdata[15:8]),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_read_data   (read_data),
        .o_status      (status),
        .o_count       (count),
        .o_first_value (first_value),
        .o_last_value  (last_value),
        .o_is_empty    (is_empty)
    );

    // pack the result word, first field lowest
    assign o_m_axis_tdata = OTW'({is_empty, last_value, first_value, count, status,
                                  read_data});

endmodule

/* rtl/core/ible_checker.sv */
// port-level checks for the indexed byte list engine
// bound to indexed_byte_list_engine; depends on nothing else
module ible_checker #(
    parameter int DEPTH = 16,
    localparam int CW  = $clog2(DEPTH + 1),
    localparam int OTW = ((27 + CW + 7) / 8) * 8
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_s_axis_tvalid,
    input logic           i_s_axis_tready,
    input logic           i_m_axis_tvalid,
    input logic           i_m_axis_tready,
    input logic [OTW-1:0] i_m_axis_tdata
);

    logic [CW-1:0] chk_count;
    logic [7:0]    chk_first;
    logic [7:0]    chk_last;
    logic          chk_empty;

    assign chk_count = i_m_axis_tdata[10 +: CW];
    assign chk_first = i_m_axis_tdata[10 + CW +: 8];
    assign chk_last  = i_m_axis_tdata[18 + CW +: 8];
    assign chk_empty = i_m_axis_tdata[26 + CW];

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("second request taken while one is in flight");

    // length never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> chk_count <= CW'(DEPTH))
        else $error("reported length above capacity");

    // empty flag agrees with the length
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> chk_empty == (chk_count == '0))
        else $error("empty flag disagrees with length");

    // an empty list shows zero head and tail
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && chk_empty |-> (chk_first == 8'd0) && (chk_last == 8'd0))
        else $error("nonzero head or tail on empty list");

endmodule

bind indexed_byte_list_engine ible_checker #(
    .DEPTH (DEPTH)
) u_ible_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
